FILE: rtl/core/oph4_pkg.sv
// oph4_pkg: shared constants, codes and control structs of the order-4
// ordinal pattern histogram; no dependencies
`default_nettype none

package oph4_pkg;

   // default sizes, handed to the top level parameters
   localparam int MAX_DELAY_DEF   = 256;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF  = 32;

   // window of four samples spans three delays
   localparam int WIN_SPAN     = 4 - 1;
   localparam int NUM_PATTERNS = 24;
   localparam int PAT_BITS     = 5;
   localparam int LAST_PATTERN = NUM_PATTERNS - 1;

   // delay register width
   localparam int DELAY_W = 9;

   // item action codes
   localparam logic ACT_PUSH    = 1'b0;
   localparam logic ACT_READOUT = 1'b1;

   typedef struct packed {
      logic               en;
      logic [DELAY_W-1:0] data;
   } cfg_wr_type;

   typedef struct packed {
      logic push;
      logic clear;
   } win_ctrl_type;

   typedef struct packed {
      logic                valid;
      logic [PAT_BITS-1:0] pattern;
   } win_hit_type;

endpackage

`default_nettype wire

FILE: rtl/core/oph4_req_if.sv
// oph4_req_if: input item channel (valid, ready, action, sample)
// depends on oph4_pkg
`default_nettype none

interface oph4_req_if import oph4_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, action, sample, input ready);
   modport sink   (input valid, action, sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/oph4_rsp_if.sv
// oph4_rsp_if: result item channel (valid, ready, pattern_index, count, last)
// depends on oph4_pkg
`default_nettype none

interface oph4_rsp_if import oph4_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [PAT_BITS-1:0]   pattern_index;
   logic [COUNT_BITS-1:0] count;
   logic                  last;

   modport source (output valid, pattern_index, count, last, input ready);
   modport sink   (input valid, pattern_index, count, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/oph4_ram.sv
// oph4_ram: generic synchronous ram, one write port and RD_PORTS
// registered read ports (read-old-data on collision); depends on oph4_pkg
`default_nettype none

module oph4_ram import oph4_pkg::*; #(
   parameter  int WIDTH    = COUNT_BITS_DEF,
   parameter  int DEPTH    = NUM_PATTERNS,
   parameter  int RD_PORTS = 1,
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr [RD_PORTS],
   output logic      [WIDTH-1:0] rd_data [RD_PORTS]
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   for (genvar p = 0; p < RD_PORTS; p++) begin : g_rd
      always_ff @(posedge clock) begin
         rd_data[p] <= mem_ff[rd_addr[p]];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/oph4_window.sv
// oph4_window: delay register, circular sample history in two ram copies,
// fill level and pattern classification; depends on oph4_pkg, oph4_ram
`default_nettype none

module oph4_window import oph4_pkg::*; #(
   parameter int MAX_DELAY   = MAX_DELAY_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cfg_wr_type                    cfg_wr,
   input  wire win_ctrl_type                  ctrl,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   output win_hit_type                        hit
);

   localparam int HIST_DEPTH = WIN_SPAN * MAX_DELAY + 1;
   localparam int AW         = $clog2(HIST_DEPTH);
   localparam int FW         = $clog2(HIST_DEPTH + 1);
   localparam int DW         = $clog2(MAX_DELAY + 1);

   logic [DW-1:0] eff_delay;
   logic [AW-1:0] d1_ff, d2_ff, d3_ff, d1_in, d2_in, d3_in;
   logic [FW-1:0] thresh_ff, thresh_in;
   logic [AW-1:0] wr_ff, wr_in, wr_next;
   logic [FW-1:0] fill_ff, fill_in, fill_next;
   logic          st1_v_ff, st1_v_in;
   logic signed [SAMPLE_BITS-1:0] s_ff;
   logic [AW-1:0]          rd_addr_a [2];
   logic [AW-1:0]          rd_addr_b [1];
   logic [SAMPLE_BITS-1:0] rd_data_a [2];
   logic [SAMPLE_BITS-1:0] rd_data_b [1];
   logic signed [SAMPLE_BITS-1:0] x0, x1, x2;

   function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] p, input logic [AW-1:0] k);
      if (p >= k) begin
         return p - k;
      end
      return p - k + AW'(HIST_DEPTH);
   endfunction

   function automatic logic [PAT_BITS-1:0] classify(input logic da, input logic ca,
                                                    input logic db, input logic ba,
                                                    input logic cb, input logic dc);
      logic [PAT_BITS-1:0] p;
      if (da) begin
         if (ca) begin
            if (db) begin
               if (ba) begin
                  if (cb) p = dc ? 5'd0 : 5'd1;
                  else    p = 5'd2;
               end else begin
                  p = dc ? 5'd3 : 5'd4;
               end
            end else begin
               if (cb) p = 5'd5;
               else    p = dc ? 5'd6 : 5'd7;
            end
         end else begin
            if (db) begin
               if (ba) p = 5'd8;
               else    p = cb ? 5'd9 : 5'd10;
            end else begin
               p = 5'd11;
            end
         end
      end else begin
         if (ca) begin
            if (db)      p = 5'd12;
            else if (ba) p = cb ? 5'd13 : 5'd14;
            else         p = 5'd15;
         end else begin
            if (db) begin
               if (cb) p = dc ? 5'd16 : 5'd17;
               else    p = 5'd18;
            end else if (ba) begin
               p = dc ? 5'd19 : 5'd20;
            end else if (cb) begin
               p = 5'd21;
            end else begin
               p = dc ? 5'd22 : 5'd23;
            end
         end
      end
      return p;
   endfunction

   // delay clamp and multiples, worked out once per register write
   always_comb begin
      if (cfg_wr.data == '0) begin
         eff_delay = DW'(1);
      end else if (32'(cfg_wr.data) > 32'(MAX_DELAY)) begin
         eff_delay = DW'(MAX_DELAY);
      end else begin
         eff_delay = DW'(cfg_wr.data);
      end
      d1_in     = AW'(eff_delay);
      d2_in     = d1_in << 1;
      d3_in     = d1_in + d2_in;
      thresh_in = FW'(d3_in) + FW'(1);
   end

   always_comb begin
      wr_next   = (wr_ff == AW'(HIST_DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      fill_next = (fill_ff < FW'(HIST_DEPTH)) ? fill_ff + FW'(1) : fill_ff;
      wr_in     = ctrl.push ? wr_next : wr_ff;
      if (ctrl.clear) begin
         fill_in = '0;
      end else if (ctrl.push) begin
         fill_in = fill_next;
      end else begin
         fill_in = fill_ff;
      end
      st1_v_in     = ctrl.push && (fill_next >= thresh_ff);
      rd_addr_a[0] = tap_addr(wr_next, d3_ff);
      rd_addr_a[1] = tap_addr(wr_next, d2_ff);
      rd_addr_b[0] = tap_addr(wr_next, d1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff     <= AW'(1);
         d2_ff     <= AW'(2);
         d3_ff     <= AW'(3);
         thresh_ff <= FW'(4);
         wr_ff     <= '0;
         fill_ff   <= '0;
         st1_v_ff  <= 1'b0;
      end else begin
         if (cfg_wr.en) begin
            d1_ff     <= d1_in;
            d2_ff     <= d2_in;
            d3_ff     <= d3_in;
            thresh_ff <= thresh_in;
         end
         wr_ff    <= wr_in;
         fill_ff  <= fill_in;
         st1_v_ff <= st1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         s_ff <= sample;
      end
   end

   // copy a serves the two far taps, copy b the near one
   oph4_ram #(
      .WIDTH    (SAMPLE_BITS),
      .DEPTH    (HIST_DEPTH),
      .RD_PORTS (2)
   ) u_hist_a (
      .clock   (clock),
      .wr_en   (ctrl.push),
      .wr_addr (wr_next),
      .wr_data (sample),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   oph4_ram #(
      .WIDTH    (SAMPLE_BITS),
      .DEPTH    (HIST_DEPTH),
      .RD_PORTS (1)
   ) u_hist_b (
      .clock   (clock),
      .wr_en   (ctrl.push),
      .wr_addr (wr_next),
      .wr_data (sample),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   assign x0 = $signed(rd_data_a[0]);
   assign x1 = $signed(rd_data_a[1]);
   assign x2 = $signed(rd_data_b[0]);

   assign hit.valid   = st1_v_ff;
   assign hit.pattern = classify(s_ff < x0, x2 < x0, s_ff < x1, x1 < x0, x2 < x1, s_ff < x2);

endmodule

`default_nettype wire

FILE: rtl/core/oph4_counts.sv
// oph4_counts: pattern counter ram with read-modify-write, valid bits,
// readout sequencer and output skid buffer; depends on oph4_pkg, oph4_ram
`default_nettype none

module oph4_counts import oph4_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire win_hit_type hit,
   input  wire logic        rdo_start,
   output logic             busy,
   oph4_rsp_if.source       rsp_chan
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [NUM_PATTERNS-1:0] cnt_valid_ff;
   logic                    st2_v_ff, st2_cv_ff, fwd_hit_ff;
   logic [PAT_BITS-1:0]     st2_j_ff;
   logic [COUNT_BITS-1:0]   fwd_val_ff;
   logic                    busy_ff;
   logic [PAT_BITS-1:0]     idx_ff, idx_in;
   logic                    pend_ff, pend_cv_ff;
   logic [PAT_BITS-1:0]     pend_idx_ff;
   logic                    out_v_ff, out_last_ff, skid_v_ff, skid_last_ff;
   logic [PAT_BITS-1:0]     out_idx_ff, skid_idx_ff;
   logic [COUNT_BITS-1:0]   out_cnt_ff, skid_cnt_ff;
   logic [PAT_BITS-1:0]     rd_addr [1];
   logic [COUNT_BITS-1:0]   rd_data [1];
   logic [COUNT_BITS-1:0]   old_cnt, new_cnt, enq_cnt;
   logic                    enq_last, deq, credit_ok, rdo_issue, rdo_done;
   logic [1:0]              used;

   always_comb begin
      deq       = out_v_ff && rsp_chan.ready;
      used      = 2'(out_v_ff) + 2'(skid_v_ff) + 2'(pend_ff);
      credit_ok = (used < 2'd2) || ((used == 2'd2) && deq);
      // readout waits until no count update is in flight
      rdo_issue = busy_ff && !hit.valid && !st2_v_ff && credit_ok;
      rdo_done  = rdo_issue && (idx_ff == PAT_BITS'(LAST_PATTERN));
      idx_in    = rdo_done ? '0 : idx_ff + PAT_BITS'(1);
      rd_addr[0] = hit.valid ? hit.pattern : idx_ff;
      old_cnt   = fwd_hit_ff ? fwd_val_ff : (st2_cv_ff ? rd_data[0] : '0);
      new_cnt   = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_BITS'(1);
      enq_cnt   = pend_cv_ff ? rd_data[0] : '0;
      enq_last  = (pend_idx_ff == PAT_BITS'(LAST_PATTERN));
   end

   oph4_ram #(
      .WIDTH    (COUNT_BITS),
      .DEPTH    (NUM_PATTERNS),
      .RD_PORTS (1)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (st2_v_ff),
      .wr_addr (st2_j_ff),
      .wr_data (new_cnt),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= '0;
         st2_v_ff     <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         out_v_ff     <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else begin
         st2_v_ff   <= hit.valid;
         // back-to-back hit on the entry being written this cycle
         fwd_hit_ff <= hit.valid && st2_v_ff && (st2_j_ff == hit.pattern);
         pend_ff    <= rdo_issue;

         if (rdo_done) begin
            cnt_valid_ff <= '0;
         end else if (st2_v_ff) begin
            cnt_valid_ff[st2_j_ff] <= 1'b1;
         end

         if (rdo_start) begin
            busy_ff <= 1'b1;
         end else if (rdo_done) begin
            busy_ff <= 1'b0;
         end
         if (rdo_issue) begin
            idx_ff <= idx_in;
         end

         if (!out_v_ff || deq) begin
            if (skid_v_ff) begin
               out_v_ff  <= 1'b1;
               skid_v_ff <= pend_ff;
            end else begin
               out_v_ff  <= pend_ff;
            end
         end else if (pend_ff) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      st2_j_ff    <= hit.pattern;
      st2_cv_ff   <= cnt_valid_ff[hit.pattern];
      fwd_val_ff  <= new_cnt;
      pend_idx_ff <= idx_ff;
      pend_cv_ff  <= cnt_valid_ff[idx_ff];
      if (!out_v_ff || deq) begin
         if (skid_v_ff) begin
            out_idx_ff   <= skid_idx_ff;
            out_cnt_ff   <= skid_cnt_ff;
            out_last_ff  <= skid_last_ff;
            skid_idx_ff  <= pend_idx_ff;
            skid_cnt_ff  <= enq_cnt;
            skid_last_ff <= enq_last;
         end else begin
            out_idx_ff   <= pend_idx_ff;
            out_cnt_ff   <= enq_cnt;
            out_last_ff  <= enq_last;
         end
      end else if (pend_ff) begin
         skid_idx_ff  <= pend_idx_ff;
         skid_cnt_ff  <= enq_cnt;
         skid_last_ff <= enq_last;
      end
   end

   assign busy                   = busy_ff;
   assign rsp_chan.valid         = out_v_ff;
   assign rsp_chan.pattern_index = out_idx_ff;
   assign rsp_chan.count         = out_cnt_ff;
   assign rsp_chan.last          = out_last_ff;

   a_no_hit_in_readout: assert property (@(posedge clock) disable iff (reset)
      hit.valid |-> !busy_ff)
      else $error("window hit arrived during readout");

   a_buffer_room: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !(out_v_ff && skid_v_ff))
      else $error("readout data arrived with output buffer full");

   a_readout_clears: assert property (@(posedge clock) disable iff (reset)
      rdo_done |=> (cnt_valid_ff == '0) && !busy_ff)
      else $error("counts not cleared after readout");

   a_fwd_needs_update: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> st2_v_ff)
      else $error("forwarding without a pending update");

endmodule

`default_nettype wire

FILE: rtl/core/ordinal_pattern_histogram_order4.sv
// order-4 ordinal pattern histogram: push items one per cycle back to back unless busy;
// a push's count passes st1 and st2 before it lands in the counter ram. readout item:
// first result via busy, pend and out registers (later behind a push), then one per
// cycle while rsp is ready, 24 in all; req ready stays low until the last read issues.
// reset (synchronous): clears counts via valid bits, fill level, write pointer, delay
// to 1; sample history is left as is, no clearing pass.
`default_nettype none

module ordinal_pattern_histogram_order4 import oph4_pkg::*; #(
   parameter int MAX_DELAY   = MAX_DELAY_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   oph4_req_if.sink                req_chan,
   oph4_rsp_if.source              rsp_chan,
   input  wire logic               csr_write_enable,
   input  wire logic [DELAY_W-1:0] csr_write_data
);

   logic         busy;
   logic         accept;
   cfg_wr_type   cfg_wr;
   win_ctrl_type ctrl;
   win_hit_type  hit;

   // items are held off only while a readout walks the counters
   assign req_chan.ready = !busy;
   assign accept         = req_chan.valid && !busy;

   // push writes the history, readout clears the fill level and starts the walk
   assign ctrl.push  = accept && (req_chan.action == ACT_PUSH);
   assign ctrl.clear = accept && (req_chan.action == ACT_READOUT);

   assign cfg_wr.en   = csr_write_enable;
   assign cfg_wr.data = csr_write_data;

   // history store and classification: ram read at accept, pattern in the cycle after
   oph4_window #(
      .MAX_DELAY   (MAX_DELAY),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .cfg_wr (cfg_wr),
      .ctrl   (ctrl),
      .sample (req_chan.sample),
      .hit    (hit)
   );

   // counter ram read-modify-write with forwarding, and the readout sequencer
   oph4_counts #(
      .COUNT_BITS (COUNT_BITS)
   ) u_counts (
      .clock     (clock),
      .reset     (reset),
      .hit       (hit),
      .rdo_start (ctrl.clear),
      .busy      (busy),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
